// ----- src/bcr_pkg.sv -----
// ----------------------------------------------------------------------------
// bcr_pkg
// shared types, character codes, reply codes and keyword tables for the
// brace framed command recognizer
// ----------------------------------------------------------------------------
package bcr_pkg;

   // character codes
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   // reply codes
   localparam logic [2:0] KIND_ID         = 3'd0;
   localparam logic [2:0] KIND_INFO       = 3'd1;
   localparam logic [2:0] KIND_TOGGLE_ON  = 3'd2;
   localparam logic [2:0] KIND_TOGGLE_OFF = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN    = 3'd4;
   localparam logic [2:0] KIND_ABORT      = 3'd5;

   // register indexes and reset values
   localparam logic [7:0]  CSR_TIMEOUT_LIMIT = 8'd0;
   localparam logic [7:0]  CSR_MAX_LENGTH    = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET     = 16'd1000;
   localparam logic [7:0]  MAX_LENGTH_RESET  = 8'd100;

   // keywords, in order of priority
   localparam int KW_COUNT   = 4;
   localparam int KW_MAX_LEN = 21;
   localparam int KW_IDX_ID     = 0;
   localparam int KW_IDX_INFO   = 1;
   localparam int KW_IDX_TOGGLE = 2;
   localparam int KW_IDX_TRUE   = 3;

   localparam logic [19*8-1:0] KW_ID_TEXT     = {"request_platform", "_id"};
   localparam logic [21*8-1:0] KW_INFO_TEXT   = {"request_platform", "_info"};
   localparam logic [14*8-1:0] KW_TOGGLE_TEXT = {"toggle", "_receive"};
   localparam logic [4*8-1:0]  KW_TRUE_TEXT   = "true";

   typedef logic [4:0] progress_type;

   typedef struct packed {
      logic [2:0] reply_kind;
      logic       notify_enable;
      logic       last;
   } result_type;

   // up to two results per item, the second only with the first
   typedef struct packed {
      logic       push_first;
      logic       push_second;
      result_type first;
      result_type second;
   } push_type;

   function automatic int kw_len(input int kw);
      int n;
      case (kw)
         KW_IDX_ID:     n = 19;
         KW_IDX_INFO:   n = 21;
         KW_IDX_TOGGLE: n = 14;
         KW_IDX_TRUE:   n = 4;
         default:       n = 0;
      endcase
      return n;
   endfunction

   // character at position pos of a keyword, zero past its end
   function automatic logic [7:0] kw_char(input int kw, input int pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (kw)
         KW_IDX_ID:     if (pos >= 0 && pos < 19) ch = KW_ID_TEXT[(18 - pos)*8 +: 8];
         KW_IDX_INFO:   if (pos >= 0 && pos < 21) ch = KW_INFO_TEXT[(20 - pos)*8 +: 8];
         KW_IDX_TOGGLE: if (pos >= 0 && pos < 14) ch = KW_TOGGLE_TEXT[(13 - pos)*8 +: 8];
         KW_IDX_TRUE:   if (pos >= 0 && pos < 4)  ch = KW_TRUE_TEXT[(3 - pos)*8 +: 8];
         default:       ch = 8'h00;
      endcase
      return ch;
   endfunction

   // true when the first j chars of the keyword end the first p chars
   function automatic logic kw_border(input int kw, input int p, input int j);
      logic ok;
      int   i;
      ok = 1'b1;
      for (i = 0; i < j; i++) begin
         if (kw_char(kw, i) != kw_char(kw, p - j + i)) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

// ----- src/bcr_matchers.sv -----
// ----------------------------------------------------------------------------
// bcr_matchers
// four substring matchers, each a prefix automaton with a sticky found flag
// ----------------------------------------------------------------------------
module bcr_matchers (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic                        clear,
   input  logic [7:0]                  char_in,
   output logic [bcr_pkg::KW_COUNT-1:0] found_next
);
   import bcr_pkg::*;

   progress_type                progress_ff [KW_COUNT];
   progress_type                progress_in [KW_COUNT];
   logic         [KW_COUNT-1:0] found_ff;
   logic         [KW_COUNT-1:0] found_in;
   progress_type                advance     [KW_COUNT];

   // longest keyword prefix that ends the text seen so far plus this char
   always_comb begin
      int w;
      int pp;
      int k;
      int n;
      for (w = 0; w < KW_COUNT; w++) begin
         n = kw_len(w);
         advance[w] = '0;
         for (pp = 0; pp <= KW_MAX_LEN; pp++) begin
            if (pp <= n && progress_ff[w] == 5'(pp)) begin
               for (k = 1; k <= KW_MAX_LEN; k++) begin
                  if (k <= pp + 1 && k <= n && char_in == kw_char(w, k - 1) &&
                      kw_border(w, pp, k - 1)) begin
                     advance[w] = 5'(k);
                  end
               end
            end
         end
      end
   end

   always_comb begin
      int w;
      for (w = 0; w < KW_COUNT; w++) begin
         progress_in[w] = progress_ff[w];
         found_next[w]  = found_ff[w];
         if (step) begin
            progress_in[w] = advance[w];
            if (advance[w] == 5'(kw_len(w))) found_next[w] = 1'b1;
         end
         found_in[w] = clear ? 1'b0 : found_next[w];
         if (clear) progress_in[w] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= '0;
         for (int w = 0; w < KW_COUNT; w++) progress_ff[w] <= '0;
      end else begin
         found_ff <= found_in;
         for (int w = 0; w < KW_COUNT; w++) progress_ff[w] <= progress_in[w];
      end
   end

endmodule

// ----- src/bcr_result_queue.sv -----
// ----------------------------------------------------------------------------
// bcr_result_queue
// four entry result queue, takes up to two words a cycle and gives one while rsp_ready is high
// ----------------------------------------------------------------------------
module bcr_result_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bcr_pkg::push_type    push,
   output logic                 room_for_two,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bcr_pkg::result_type  rsp_word
);
   import bcr_pkg::*;

   result_type  entry_ff [4];
   logic [1:0]  wr_ptr_ff;
   logic [1:0]  wr_ptr_in;
   logic [1:0]  rd_ptr_ff;
   logic [1:0]  rd_ptr_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic        pop;
   logic [2:0]  push_count;

   assign rsp_valid    = (count_ff != 3'd0);
   assign rsp_word     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= 3'd2);
   assign pop          = rsp_valid && rsp_ready;
   assign push_count   = {2'b00, push.push_first} + {2'b00, push.push_second};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_count[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + push_count - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.push_first)  entry_ff[wr_ptr_ff]        <= push.first;
      if (push.push_second) entry_ff[wr_ptr_ff + 2'd1] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/brace_framed_command_recognizer.sv -----
// ----------------------------------------------------------------------------
// brace_framed_command_recognizer
// recognizes brace framed text commands in a serial byte stream and replies
// ----------------------------------------------------------------------------
// Each req word is either an idle tick (command 0) or a received byte
// (command 1). Outside a message everything but an opening brace is dropped.
// Inside a message every byte except CR/LF is counted and fed to four keyword
// matchers, braces track nesting depth, and every word counts as one tick.
// When the braces balance one reply word comes out (platform id, platform
// info, toggle on, toggle off or unknown); a message longer than max_length
// stored bytes or older than timeout_limit ticks gives an abort word, which
// may follow a reply from the same req word. The last flag marks the final
// rsp word of a req word. Timing: a req word is registered in the input
// register, then decoded into a four entry result queue once the queue has
// room for two results, and rsp offers the oldest queued result; a new req
// word can be taken every cycle while the queue has room for two results;
// sustained throughput is one word per cycle as long as rsp_ready keeps the
// queue drained. Config writes are always ready and take effect at once.
// ----------------------------------------------------------------------------
module brace_framed_command_recognizer (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_rx_byte,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_reply_kind,
   output logic        rsp_notify_enable,
   output logic        rsp_last,
   // config writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bcr_pkg::*;

   // config registers
   logic [15:0] timeout_limit_ff;
   logic [7:0]  max_length_ff;

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic        in_command_ff;
   logic [7:0]  in_byte_ff;

   // message state
   logic        receiving_ff;
   logic        receiving_in;
   logic [7:0]  depth_ff;
   logic [7:0]  depth_in;
   logic [7:0]  length_ff;
   logic [7:0]  length_in;
   logic [15:0] ticks_ff;
   logic [15:0] ticks_in;
   logic        notify_ff;
   logic        notify_in;

   // decode
   logic                process;
   logic                room_for_two;
   logic                has_byte;
   logic                is_lbrace;
   logic                is_rbrace;
   logic                is_crlf;
   logic                start;
   logic                run;
   logic                store;
   logic [7:0]          depth_step;
   logic [7:0]          length_step;
   logic [15:0]         ticks_step;
   logic                reply;
   logic                abort;
   logic [2:0]          reply_kind;
   logic                match_step;
   logic                match_clear;
   logic [KW_COUNT-1:0] found;
   push_type            push;
   result_type          rsp_word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_limit_ff <= TIMEOUT_RESET;
         max_length_ff    <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TIMEOUT_LIMIT) timeout_limit_ff <= csr_data;
         else if (csr_index == CSR_MAX_LENGTH) max_length_ff <= csr_data[7:0];
      end
   end

   // the input register frees up whenever its word is decoded
   assign process     = in_valid_ff && room_for_two;
   assign req_ready   = !in_valid_ff || process;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_command_ff <= req_command;
         in_byte_ff    <= req_rx_byte;
      end
   end

   // byte classes
   assign has_byte  = in_command_ff;
   assign is_lbrace = has_byte && (in_byte_ff == CHAR_LBRACE);
   assign is_rbrace = has_byte && (in_byte_ff == CHAR_RBRACE);
   assign is_crlf   = has_byte && (in_byte_ff == CHAR_LF || in_byte_ff == CHAR_CR);

   // opening brace while waiting starts a message
   assign start = process && !receiving_ff && is_lbrace;
   // any word while receiving, CR/LF only bump the tick count
   assign run   = process && receiving_ff;
   assign store = has_byte && !is_crlf;

   // saturating counters and wrapping depth
   always_comb begin
      ticks_step  = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;
      length_step = store ? ((length_ff == 8'hFF) ? length_ff : length_ff + 8'd1)
                          : length_ff;
      depth_step  = depth_ff;
      if (is_lbrace)      depth_step = depth_ff + 8'd1;
      else if (is_rbrace) depth_step = depth_ff - 8'd1;
   end

   assign reply = run && !is_crlf && (depth_step == 8'd0);
   assign abort = run && !is_crlf &&
                  ((length_step > max_length_ff) || (ticks_step > timeout_limit_ff));

   // keyword priority, found flags include this byte
   always_comb begin
      notify_in = notify_ff;
      if (found[KW_IDX_ID])        reply_kind = KIND_ID;
      else if (found[KW_IDX_INFO]) reply_kind = KIND_INFO;
      else if (found[KW_IDX_TOGGLE]) begin
         if (found[KW_IDX_TRUE]) reply_kind = KIND_TOGGLE_ON;
         else                    reply_kind = KIND_TOGGLE_OFF;
      end else                   reply_kind = KIND_UNKNOWN;
      if (reply && reply_kind == KIND_TOGGLE_ON)  notify_in = 1'b1;
      if (reply && reply_kind == KIND_TOGGLE_OFF) notify_in = 1'b0;
   end

   assign match_step  = start || (run && store);
   assign match_clear = reply || abort;

   bcr_matchers u_matchers (
      .clock      (clock),
      .reset      (reset),
      .step       (match_step),
      .clear      (match_clear),
      .char_in    (in_byte_ff),
      .found_next (found)
   );

   // next message state
   always_comb begin
      receiving_in = receiving_ff;
      depth_in     = depth_ff;
      length_in    = length_ff;
      ticks_in     = ticks_ff;
      if (start) begin
         receiving_in = 1'b1;
         depth_in     = 8'd1;
         length_in    = 8'd1;
         ticks_in     = 16'd1;
      end else if (run) begin
         ticks_in = ticks_step;
         if (!is_crlf) begin
            depth_in  = depth_step;
            length_in = length_step;
         end
         if (reply || abort) begin
            receiving_in = 1'b0;
            depth_in     = '0;
            length_in    = '0;
            ticks_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         depth_ff     <= '0;
         length_ff    <= '0;
         ticks_ff     <= '0;
         notify_ff    <= 1'b0;
      end else begin
         receiving_ff <= receiving_in;
         depth_ff     <= depth_in;
         length_ff    <= length_in;
         ticks_ff     <= ticks_in;
         notify_ff    <= notify_in;
      end
   end

   // reply first, abort behind it; the abort alone goes in the first slot
   always_comb begin
      push.push_first            = reply || abort;
      push.push_second           = reply && abort;
      push.first.reply_kind      = reply ? reply_kind : KIND_ABORT;
      push.first.notify_enable   = notify_in;
      push.first.last            = !(reply && abort);
      push.second.reply_kind     = KIND_ABORT;
      push.second.notify_enable  = notify_in;
      push.second.last           = 1'b1;
   end

   bcr_result_queue u_result_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word)
   );

   assign rsp_reply_kind    = rsp_word.reply_kind;
   assign rsp_notify_enable = rsp_word.notify_enable;
   assign rsp_last          = rsp_word.last;

endmodule
